FILE: rtl/tse_pkg.sv
// Package for the TLS server-name extractor.
// Holds the parse phase encoding, result kinds, protocol constants and the result type.
// No dependencies; the extractor, parser, checker and testbench import it.
package tse_pkg;

	localparam int LENGTH_BITS_DEF = 16;

	localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
	localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
	localparam int          FIXED_PREFIX    = 43;
	localparam logic [15:0] SNI_EXT_TYPE    = 16'h0000;
	localparam logic [7:0]  HOST_NAME_TYPE  = 8'h00;

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;

	typedef enum logic [8:0] {
		PH_RECORD    = 9'b000000001,
		PH_SESSION   = 9'b000000010,
		PH_CIPHER    = 9'b000000100,
		PH_COMPRESS  = 9'b000001000,
		PH_EXTS_LEN  = 9'b000010000,
		PH_EXT_HDR   = 9'b000100000,
		PH_SNI_LIST  = 9'b001000000,
		PH_SNI_ENTRY = 9'b010000000,
		PH_NAME      = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] name_byte;
		logic       name_end;
	} tse_result_t;

endpackage

FILE: rtl/tse_if.sv
// Channel interfaces of the TLS server-name extractor: payload bytes in, results out.
// Depends on nothing; the payload length width is an interface parameter.
interface tse_pkt_if #(
	parameter int LENGTH_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [7:0]             payload_byte;
	logic [LENGTH_BITS-1:0] payload_length;
	logic                   payload_end;

	modport source (output valid, payload_byte, payload_length, payload_end, input ready);
	modport sink (input valid, payload_byte, payload_length, payload_end, output ready);
endinterface

interface tse_sni_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] name_byte;
	logic       name_end;

	modport source (output valid, result_kind, name_byte, name_end, input ready);
	modport sink (input valid, result_kind, name_byte, name_end, output ready);
endinterface

FILE: rtl/tls_sni_extractor.sv
// Top level of the TLS server-name extractor: input register, parser and result register.
// Depends on tse_pkg, tse_if (channel interfaces) and tse_parser.
//
// The pkt channel carries one payload byte per transaction together with the
// payload's declared length and an end flag on its final byte. The sni channel
// carries the results: the bytes of the first host_name of a ClientHello, the
// last one marked by name_end, or a single empty-name or no-name result.
// A byte that produces no result simply updates the parse state.
// A byte accepted into the input register has its result written into the result register
// once that register is free. One byte is taken in every cycle unless the receiver stalls; each byte is
// parsed combinationally between the input register and the result register.
// Reset clears the valid flags of both registers and returns the parser to the record header.
// When the receiver stalls, the result is held in the result register and the
// input register keeps one more byte; pkt.ready then follows sni.ready until
// the result is taken.
module tls_sni_extractor #(
	parameter int LENGTH_BITS = tse_pkg::LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tse_pkt_if.sink   pkt,
	tse_sni_if.source sni
);
	import tse_pkg::*;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic [LENGTH_BITS-1:0] len_s1;
	logic                   end_s1;
	logic                   out_valid_q;
	tse_result_t            out_q;
	logic                   out_free, advance, res_valid;
	tse_result_t            res;

	assign out_free  = !out_valid_q || sni.ready;
	assign advance   = valid_s1 && out_free;
	assign pkt.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.valid && pkt.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1 <= pkt.payload_byte;
			len_s1  <= pkt.payload_length;
			end_s1  <= pkt.payload_end;
		end
	end

	tse_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.payload_byte   (byte_s1),
		.payload_length (len_s1),
		.payload_end    (end_s1),
		.res_valid      (res_valid),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid && out_free) begin
			out_q <= res;
		end
	end

	assign sni.valid       = out_valid_q;
	assign sni.result_kind = out_q.result_kind;
	assign sni.name_byte   = out_q.name_byte;
	assign sni.name_end    = out_q.name_end;

endmodule

FILE: rtl/tse_parser.sv
// ClientHello parser: parse state registers and the per-byte next-state logic.
// Depends on tse_pkg; advances one payload byte per step and produces at most one result.
module tse_parser #(
	parameter int LENGTH_BITS = tse_pkg::LENGTH_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               payload_byte,
	input  logic [LENGTH_BITS-1:0]   payload_length,
	input  logic                     payload_end,
	output logic                     res_valid,
	output tse_pkg::tse_result_t     res
);
	import tse_pkg::*;

	localparam int OFS_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;
	localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

	logic [LENGTH_BITS-1:0] pos_q, pos_n;
	phase_t                 phase_q, phase_n;
	logic [OFS_W-1:0]       nfo_q, nfo_n;
	logic [7:0]             acc_q, acc_n;
	logic [OFS_W-1:0]       exts_end_q, exts_end_n;
	logic [OFS_W-1:0]       ext_end_q, ext_end_n;
	logic [15:0]            ext_type_q, ext_type_n;
	logic [15:0]            left_q, left_n;
	logic                   resolved_q, resolved_n;

	logic [OFS_W-1:0] p_ext, len_ext, b_ext, v_ext, diff, t, e;
	logic [15:0]      v;
	logic             active, small_d;
	logic             d0, d1, d2, d3, d5;
	logic             has;
	logic [1:0]       kind;
	logic [7:0]       nbyte;
	logic             nend;

	always_comb begin
		p_ext   = OFS_W'(pos_q);
		len_ext = OFS_W'(payload_length);
		b_ext   = OFS_W'(payload_byte);
		v       = {acc_q, payload_byte};
		v_ext   = OFS_W'(v);
		diff    = p_ext - nfo_q;
		small_d = (diff[OFS_W-1:3] == '0);
		active  = !resolved_q && (p_ext >= nfo_q);
		d0 = small_d && (diff[2:0] == 3'd0);
		d1 = small_d && (diff[2:0] == 3'd1);
		d2 = small_d && (diff[2:0] == 3'd2);
		d3 = small_d && (diff[2:0] == 3'd3);
		d5 = small_d && (diff[2:0] == 3'd5);

		pos_n      = pos_q;
		phase_n    = phase_q;
		nfo_n      = nfo_q;
		acc_n      = acc_q;
		exts_end_n = exts_end_q;
		ext_end_n  = ext_end_q;
		ext_type_n = ext_type_q;
		left_n     = left_q;
		resolved_n = resolved_q;
		t          = '0;
		e          = '0;
		has        = 1'b0;
		kind       = KIND_NONE;
		nbyte      = 8'h00;
		nend       = 1'b0;

		if (active) begin
			case (phase_q)
				PH_RECORD: begin
					if (d0 && (payload_byte != REC_HANDSHAKE ||
							len_ext <= OFS_W'(FIXED_PREFIX))) begin
						has = 1'b1;
					end else if (d5) begin
						if (payload_byte != HS_CLIENT_HELLO) begin
							has = 1'b1;
						end else begin
							nfo_n   = OFS_W'(FIXED_PREFIX);
							phase_n = PH_SESSION;
						end
					end
				end
				PH_SESSION: begin
					if (d0) begin
						t     = nfo_q + b_ext + OFS_W'(1);
						nfo_n = t;
						if (t + OFS_W'(2) > len_ext) has = 1'b1;
						else phase_n = PH_CIPHER;
					end
				end
				PH_CIPHER: begin
					if (d0) begin
						acc_n = payload_byte;
					end else if (d1) begin
						t     = nfo_q + v_ext + OFS_W'(2);
						nfo_n = t;
						if (t + OFS_W'(1) > len_ext) has = 1'b1;
						else phase_n = PH_COMPRESS;
					end
				end
				PH_COMPRESS: begin
					if (d0) begin
						t     = nfo_q + b_ext + OFS_W'(1);
						nfo_n = t;
						if (t + OFS_W'(2) > len_ext) has = 1'b1;
						else phase_n = PH_EXTS_LEN;
					end
				end
				PH_EXTS_LEN: begin
					if (d0) begin
						acc_n = payload_byte;
					end else if (d1) begin
						t          = nfo_q + OFS_W'(2);
						e          = t + v_ext;
						nfo_n      = t;
						exts_end_n = e;
						if (e > len_ext) has = 1'b1;
						else if (t + OFS_W'(4) > e) has = 1'b1;
						else phase_n = PH_EXT_HDR;
					end
				end
				PH_EXT_HDR: begin
					if (d0 || d2) begin
						acc_n = payload_byte;
					end else if (d1) begin
						ext_type_n = v;
					end else if (d3) begin
						t         = nfo_q + OFS_W'(4);
						e         = t + v_ext;
						nfo_n     = t;
						ext_end_n = e;
						if (e > exts_end_q) begin
							has = 1'b1;
						end else if (ext_type_q == SNI_EXT_TYPE &&
								t + OFS_W'(2) <= exts_end_q) begin
							phase_n = PH_SNI_LIST;
						end else begin
							nfo_n = e;
							if (e + OFS_W'(4) > exts_end_q) has = 1'b1;
						end
					end
				end
				PH_SNI_LIST: begin
					if (d0) begin
						acc_n = payload_byte;
					end else if (d1) begin
						t     = nfo_q + OFS_W'(2);
						nfo_n = t;
						if (t + v_ext > exts_end_q) has = 1'b1;
						else if (t + OFS_W'(3) > exts_end_q) has = 1'b1;
						else phase_n = PH_SNI_ENTRY;
					end
				end
				PH_SNI_ENTRY: begin
					if (d0) begin
						ext_type_n = {8'h00, payload_byte};
					end else if (d1) begin
						acc_n = payload_byte;
					end else if (d2) begin
						t     = nfo_q + OFS_W'(3);
						nfo_n = t;
						if (ext_type_q != {8'h00, HOST_NAME_TYPE} || t + v_ext > exts_end_q) begin
							has = 1'b1;
						end else if (v == 16'h0000) begin
							has  = 1'b1;
							kind = KIND_EMPTY;
						end else begin
							left_n  = v;
							phase_n = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					if (d0) begin
						has    = 1'b1;
						kind   = KIND_NAME;
						nbyte  = payload_byte;
						nfo_n  = nfo_q + OFS_W'(1);
						left_n = left_q - 16'd1;
						nend   = (left_n == 16'h0000);
					end
				end
				default: begin
					has = 1'b1;
				end
			endcase
			if (has && (kind != KIND_NAME || nend)) resolved_n = 1'b1;
		end

		if (payload_end) begin
			if (!has && !resolved_n) begin
				has  = 1'b1;
				kind = KIND_NONE;
			end
			if (has && kind == KIND_NAME) nend = 1'b1;
			pos_n      = '0;
			phase_n    = PH_RECORD;
			nfo_n      = '0;
			acc_n      = '0;
			exts_end_n = '0;
			ext_end_n  = '0;
			ext_type_n = '0;
			left_n     = '0;
			resolved_n = 1'b0;
		end else if (pos_q != POS_MAX) begin
			pos_n = pos_q + 1'b1;
		end

		res_valid       = has;
		res.result_kind = kind;
		res.name_byte   = nbyte;
		res.name_end    = nend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= PH_RECORD;
			nfo_q      <= '0;
			acc_q      <= '0;
			exts_end_q <= '0;
			ext_end_q  <= '0;
			ext_type_q <= '0;
			left_q     <= '0;
			resolved_q <= 1'b0;
		end else if (step) begin
			pos_q      <= pos_n;
			phase_q    <= phase_n;
			nfo_q      <= nfo_n;
			acc_q      <= acc_n;
			exts_end_q <= exts_end_n;
			ext_end_q  <= ext_end_n;
			ext_type_q <= ext_type_n;
			left_q     <= left_n;
			resolved_q <= resolved_n;
		end
	end

endmodule

FILE: rtl/tse_checker.sv
// Port-level checker for the TLS server-name extractor, bound to the top level.
// Depends on tse_pkg for the result kinds.
module tse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       out_end
);
	import tse_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
			$stable(out_byte) && $stable(out_end))
		else $error("Result changed while stalled.");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && out_valid && !out_ready |=> in_ready == out_ready)
		else $error("Input ready does not follow output ready with a full input stage.");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && out_ready) ##1 (!in_acc && out_ready) |=> !out_valid)
		else $error("Result appeared without an accepted byte.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_kind == KIND_NAME || out_kind == KIND_EMPTY ||
			out_kind == KIND_NONE))
		else $error("Invalid result kind.");

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pkt.valid),
	.in_ready  (pkt.ready),
	.out_valid (sni.valid),
	.out_ready (sni.ready),
	.out_kind  (sni.result_kind),
	.out_byte  (sni.name_byte),
	.out_end   (sni.name_end)
);

FILE: bench/tls_sni_extractor_tb.sv
// Self-checking testbench for tls_sni_extractor: drives ClientHello payloads and checks the server names.
// Depends on tse_pkg, the tse_pkt_if and tse_sni_if channel interfaces and the tls_sni_extractor RTL.
// A parser model in sni_tracker predicts each result as payload bytes are accepted.
`timescale 1ns / 100ps

import tse_pkg::*;

class sni_tracker;
	tse_result_t expected_sni[$];
	int unsigned bad_results;
	logic [15:0] position;
	phase_t phase;
	int unsigned field_at;
	int unsigned acc;
	int unsigned exts_end;
	int unsigned ext_end;
	int unsigned ext_code;
	int unsigned name_left;
	bit resolved;

	function new();
		bad_results = 0;
		clear();
	endfunction

	function void clear();
		position = '0;
		phase = PH_RECORD;
		field_at = 0;
		acc = 0;
		exts_end = 0;
		ext_end = 0;
		ext_code = 0;
		name_left = 0;
		resolved = 1'b0;
	endfunction

	function void parse_byte(logic [7:0] b, logic [15:0] len, logic last);
		int unsigned d;
		int unsigned v;
		int unsigned lim;
		bit emit;
		bit fail;
		bit nend;
		logic [1:0] kind;
		logic [7:0] nbyte;
		tse_result_t r;
		lim = len;
		emit = 1'b0;
		fail = 1'b0;
		nend = 1'b0;
		kind = KIND_NONE;
		nbyte = '0;
		if (!resolved && position >= field_at) begin
			d = position - field_at;
			case (phase)
				PH_RECORD: begin
					if (d == 0 && (b != REC_HANDSHAKE || lim <= FIXED_PREFIX))
						fail = 1'b1;
					else if (d == 5) begin
						if (b != HS_CLIENT_HELLO)
							fail = 1'b1;
						else begin
							field_at = FIXED_PREFIX;
							phase = PH_SESSION;
						end
					end
				end
				PH_SESSION: begin
					if (d == 0) begin
						field_at += 1 + b;
						if (field_at + 2 > lim)
							fail = 1'b1;
						else
							phase = PH_CIPHER;
					end
				end
				PH_CIPHER: begin
					if (d == 0)
						acc = b;
					else if (d == 1) begin
						v = (acc << 8) | b;
						field_at += 2 + v;
						if (field_at + 1 > lim)
							fail = 1'b1;
						else
							phase = PH_COMPRESS;
					end
				end
				PH_COMPRESS: begin
					if (d == 0) begin
						field_at += 1 + b;
						if (field_at + 2 > lim)
							fail = 1'b1;
						else
							phase = PH_EXTS_LEN;
					end
				end
				PH_EXTS_LEN: begin
					if (d == 0)
						acc = b;
					else if (d == 1) begin
						v = (acc << 8) | b;
						field_at += 2;
						exts_end = field_at + v;
						if (exts_end > lim || field_at + 4 > exts_end)
							fail = 1'b1;
						else
							phase = PH_EXT_HDR;
					end
				end
				PH_EXT_HDR: begin
					if (d == 0 || d == 2)
						acc = b;
					else if (d == 1)
						ext_code = (acc << 8) | b;
					else if (d == 3) begin
						v = (acc << 8) | b;
						field_at += 4;
						ext_end = field_at + v;
						if (ext_end > exts_end)
							fail = 1'b1;
						else if (ext_code == SNI_EXT_TYPE && field_at + 2 <= exts_end)
							phase = PH_SNI_LIST;
						else begin
							field_at = ext_end;
							if (field_at + 4 > exts_end)
								fail = 1'b1;
						end
					end
				end
				PH_SNI_LIST: begin
					if (d == 0)
						acc = b;
					else if (d == 1) begin
						v = (acc << 8) | b;
						field_at += 2;
						if (field_at + v > exts_end || field_at + 3 > exts_end)
							fail = 1'b1;
						else
							phase = PH_SNI_ENTRY;
					end
				end
				PH_SNI_ENTRY: begin
					if (d == 0)
						ext_code = b;
					else if (d == 1)
						acc = b;
					else if (d == 2) begin
						v = (acc << 8) | b;
						field_at += 3;
						if (ext_code != HOST_NAME_TYPE || field_at + v > exts_end)
							fail = 1'b1;
						else if (v == 0) begin
							emit = 1'b1;
							kind = KIND_EMPTY;
						end else begin
							name_left = v;
							phase = PH_NAME;
						end
					end
				end
				PH_NAME: begin
					if (d == 0) begin
						emit = 1'b1;
						kind = KIND_NAME;
						nbyte = b;
						field_at += 1;
						name_left = (name_left - 1) & 16'hFFFF;
						nend = (name_left == 0);
					end
				end
				default: fail = 1'b1;
			endcase
			if (fail) begin
				emit = 1'b1;
				kind = KIND_NONE;
			end
			if (emit && (kind != KIND_NAME || nend))
				resolved = 1'b1;
		end
		if (last) begin
			if (!emit && !resolved) begin
				emit = 1'b1;
				kind = KIND_NONE;
			end
			if (emit && kind == KIND_NAME)
				nend = 1'b1;
			clear();
		end else if (position != '1) begin
			position++;
		end
		if (emit) begin
			r.result_kind = kind;
			r.name_byte = nbyte;
			r.name_end = nend;
			expected_sni.push_back(r);
		end
	endfunction

	function void report(string what, tse_result_t want, tse_result_t got);
		bad_results++;
		if (bad_results <= 10)
			$display("%0t %s: expected kind %0d byte %02h end %0b, got kind %0d byte %02h end %0b",
				$time, what, want.result_kind, want.name_byte, want.name_end,
				got.result_kind, got.name_byte, got.name_end);
	endfunction

	function void check_sni(tse_result_t got);
		tse_result_t want;
		if (expected_sni.size() == 0) begin
			report("result with nothing expected", '0, got);
		end else begin
			want = expected_sni.pop_front();
			if (got.result_kind !== want.result_kind || got.name_byte !== want.name_byte ||
					got.name_end !== want.name_end)
				report("result mismatch", want, got);
		end
	endfunction

	function void check_drained();
		if (expected_sni.size() != 0) begin
			bad_results += expected_sni.size();
			$display("%0d expected results never arrived", expected_sni.size());
		end
	endfunction
endclass

module tls_sni_extractor_tb;
	localparam int LEN_BITS = LENGTH_BITS_DEF;
	localparam int LIMIT = 1000000;
	localparam int TOTAL_ITEMS = 1900;

	logic clk = 1'b0;
	logic arst_n;
	int unsigned cycle_count = 0;
	int pkt_gap_max = 0;
	int sni_stall_max = 0;
	int items_sent = 0;
	bit len_jitter = 1'b0;
	logic [7:0] frame[$];
	int exts_at;
	sni_tracker tracker = new();

	tse_pkt_if #(.LENGTH_BITS(LEN_BITS)) pkt_ch ();
	tse_sni_if sni_ch ();

	tls_sni_extractor #(.LENGTH_BITS(LEN_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.sni(sni_ch)
	);

	always #5 clk = ~clk;

	function automatic int draw_idle_max();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			default: return 14;
		endcase
	endfunction

	function automatic void put16(int at, int unsigned v);
		frame[at] = 8'(v >> 8);
		frame[at + 1] = 8'(v);
	endfunction

	function automatic void push16(int unsigned v);
		frame.push_back(8'(v >> 8));
		frame.push_back(8'(v));
	endfunction

	function automatic void push_random(int n);
		repeat (n) frame.push_back(8'($urandom));
	endfunction

	function automatic void start_hello(int sid, int cs, int cm);
		frame.delete();
		frame.push_back(REC_HANDSHAKE);
		push16(16'h0301);
		push16($urandom_range(0, 16'hFFFF));
		frame.push_back(HS_CLIENT_HELLO);
		push_random(FIXED_PREFIX - 6);
		frame.push_back(8'(sid));
		push_random(sid);
		push16(cs);
		push_random(cs);
		frame.push_back(8'(cm));
		push_random(cm);
		exts_at = frame.size();
		push16(0);
	endfunction

	function automatic void add_filler(int n);
		push16($urandom_range(1, 16'hFFFF));
		push16(n);
		push_random(n);
	endfunction

	function automatic void add_sni(int name_n, logic [7:0] host_kind);
		push16(SNI_EXT_TYPE);
		push16(name_n + 5);
		push16(name_n + 3);
		frame.push_back(host_kind);
		push16(name_n);
		push_random(name_n);
	endfunction

	function automatic void close_hello();
		put16(exts_at, frame.size() - exts_at - 2);
	endfunction

	// The session id, cipher and compression lengths fields sit at 43, 44 and 48,
	// the extensions length at 50 and the first extension at 52.
	function automatic void basic_hello(int name_n);
		start_hello(0, 2, 1);
		add_sni(name_n, HOST_NAME_TYPE);
		close_hello();
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [15:0] len, input logic last);
		int gap;
		gap = $urandom_range(0, pkt_gap_max);
		if (gap > 0) begin
			pkt_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt_ch.valid = 1'b1;
		pkt_ch.payload_byte = b;
		pkt_ch.payload_length = len;
		pkt_ch.payload_end = last;
		do @(posedge clk); while (!pkt_ch.ready);
		tracker.parse_byte(b, len, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] len, input int count);
		logic [15:0] l;
		for (int i = 0; i < count; i++) begin
			l = (len_jitter && $urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : len;
			send_byte(frame[i], l, i == count - 1);
		end
	endtask

	task automatic send_all();
		send_frame(16'(frame.size()), frame.size());
	endtask

	task automatic random_packet();
		int sid;
		int cs;
		int cut;
		logic [15:0] len;
		pkt_gap_max = draw_idle_max();
		sni_stall_max = draw_idle_max();
		if ($urandom_range(0, 9) == 0) begin
			frame.delete();
			push_random($urandom_range(1, 80));
			if ($urandom_range(0, 1))
				frame[0] = REC_HANDSHAKE;
			if (frame.size() > 5 && $urandom_range(0, 1))
				frame[5] = HS_CLIENT_HELLO;
		end else begin
			sid = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 8);
			cs = 2 * $urandom_range(1, 6) + ($urandom_range(0, 9) == 0);
			start_hello(sid, cs, $urandom_range(1, 3));
			repeat ($urandom_range(0, 3)) add_filler($urandom_range(0, 8));
			if ($urandom_range(0, 9) != 0)
				add_sni(($urandom_range(0, 15) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 24),
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : HOST_NAME_TYPE);
			repeat ($urandom_range(0, 2)) add_filler($urandom_range(0, 8));
			close_hello();
		end
		len = 16'(frame.size());
		cut = frame.size();
		case ($urandom_range(0, 9))
			0: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
			1: frame[$urandom_range(0, frame.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
			2: cut = $urandom_range(1, frame.size());
			3: begin
				if ($urandom_range(0, 1))
					len = 16'($urandom_range(1, 16'hFFFF));
				else
					len = 16'(frame.size() + $urandom_range(0, 8) - 4);
				if (len == 0)
					len = 16'd1;
			end
			4: len_jitter = 1'b1;
			default: ;
		endcase
		send_frame(len, cut);
		len_jitter = 1'b0;
	endtask

	initial begin : watchdog
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tls_sni_extractor_tb: FAIL");
		$finish;
	end

	initial begin : sni_sink
		int stall;
		tse_result_t got;
		sni_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, sni_stall_max);
			if (stall > 0) begin
				sni_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			sni_ch.ready = 1'b1;
			do @(posedge clk); while (!sni_ch.valid);
			got.result_kind = sni_ch.result_kind;
			got.name_byte = sni_ch.name_byte;
			got.name_end = sni_ch.name_end;
			tracker.check_sni(got);
			@(negedge clk);
		end
	end

	initial begin : payload_source
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.payload_byte = '0;
		pkt_ch.payload_length = '0;
		pkt_ch.payload_end = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		pkt_gap_max = 2;
		sni_stall_max = 2;

		basic_hello(4);
		frame[0] = 8'h17;
		send_all();
		basic_hello(4);
		send_frame(16'd43, frame.size());
		basic_hello(4);
		send_frame(16'd44, 44);
		basic_hello(4);
		frame[5] = 8'h02;
		send_all();
		basic_hello(1);
		send_all();
		basic_hello(0);
		send_all();
		start_hello(0, 2, 1);
		add_sni(3, 8'h01);
		close_hello();
		send_all();
		start_hello(32, 2, 1);
		add_sni(5, HOST_NAME_TYPE);
		close_hello();
		frame[43] = 8'hFF;
		send_all();
		basic_hello(4);
		put16(44, 16'hFFFF);
		send_all();
		basic_hello(4);
		frame[48] = 8'hFF;
		send_all();
		basic_hello(4);
		put16(50, 16'hFFFF);
		send_all();
		basic_hello(4);
		put16(50, 0);
		send_all();
		start_hello(0, 2, 1);
		add_filler(0);
		add_filler(6);
		add_sni(12, HOST_NAME_TYPE);
		add_filler(3);
		close_hello();
		send_all();
		start_hello(0, 2, 1);
		add_filler(2);
		close_hello();
		put16(54, 16'hFFFF);
		send_all();
		start_hello(0, 2, 1);
		add_filler(5);
		close_hello();
		send_all();
		basic_hello(4);
		put16(56, 16'hFFFF);
		send_all();
		// A server-name extension too short to hold its list length is skipped like any other.
		start_hello(0, 2, 1);
		push16(SNI_EXT_TYPE);
		push16(0);
		close_hello();
		send_all();
		basic_hello(4);
		put16(59, 14);
		send_all();
		basic_hello(10);
		send_frame(16'(frame.size()), frame.size() - 5);
		basic_hello(10);
		send_frame(16'(frame.size()), 10);
		frame.delete();
		frame.push_back(REC_HANDSHAKE);
		send_frame(16'd100, 1);
		frame[0] = 8'h00;
		send_frame(16'd1, 1);
		basic_hello(300);
		send_all();
		// The name list may run past the end of its own extension.
		start_hello(0, 2, 1);
		add_sni(5, HOST_NAME_TYPE);
		add_filler(4);
		close_hello();
		put16(54, 0);
		send_all();
		basic_hello(6);
		len_jitter = 1'b1;
		send_all();
		len_jitter = 1'b0;

		while (items_sent < TOTAL_ITEMS)
			random_packet();
		pkt_ch.valid = 1'b0;

		while (tracker.expected_sni.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		tracker.check_drained();
		if (tracker.bad_results == 0)
			$display("tls_sni_extractor_tb: PASS");
		else
			$display("tls_sni_extractor_tb: FAIL");
		$finish;
	end
endmodule
